// ===== src/lcg_random_range_generator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LCG random range generator
// Shared helpers that wrap concurrent assertions on a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef LCG_RANDOM_RANGE_GENERATOR_UNIT_ASSERT_SVH
`define LCG_RANDOM_RANGE_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lcg_rrg_pkg.sv =====
// ----------------------------------------------------------------------------
// LCG random range generator package
// Widths, generator constants, sequencer states and shared structs.
// ----------------------------------------------------------------------------
package lcg_rrg_pkg;

   localparam int STATE_WIDTH = 64;
   localparam int HALF_WIDTH  = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int DRAW_SHIFT  = 33;
   localparam int DRAW_WIDTH  = STATE_WIDTH - DRAW_SHIFT;
   localparam int COUNT_WIDTH = $clog2(DRAW_WIDTH + 1);

   localparam logic [STATE_WIDTH-1:0] LCG_MULTIPLIER = 64'h5851_F42D_4C95_7F2D;
   localparam logic [STATE_WIDTH-1:0] LCG_INCREMENT  = 64'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LL,
      ST_MUL_HL,
      ST_MUL_LH,
      ST_MOD,
      ST_DONE
   } state_type;

   // Handshake between the sequencer and the remainder unit.
   typedef struct packed {
      logic                  start;
      logic [DRAW_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } mod_ctrl_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] remainder;
   } mod_status_type;

endpackage

// ===== src/lcg_rrg_mod.sv =====
// ----------------------------------------------------------------------------
// LCG random range generator remainder unit
// Restoring remainder of the draw by the range width, one bit per cycle.
// ----------------------------------------------------------------------------
module lcg_rrg_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  lcg_rrg_pkg::mod_ctrl_type   ctrl,
   output lcg_rrg_pkg::mod_status_type status
);

   logic [lcg_rrg_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                done_ff, done_in;
   logic [lcg_rrg_pkg::DRAW_WIDTH-1:0]  dividend_ff, dividend_in;
   logic [lcg_rrg_pkg::DATA_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [lcg_rrg_pkg::DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [lcg_rrg_pkg::DATA_WIDTH:0]    trial;
   logic [lcg_rrg_pkg::DATA_WIDTH+1:0]  diff;

   // The partial remainder stays below the divisor, so the trial value
   // stays below twice the divisor and one subtract restores it.
   assign trial = {rem_ff, dividend_ff[lcg_rrg_pkg::DRAW_WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};

   always_comb begin
      count_in    = count_ff;
      done_in     = 1'b0;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (ctrl.start) begin
         count_in    = lcg_rrg_pkg::COUNT_WIDTH'(lcg_rrg_pkg::DRAW_WIDTH);
         dividend_in = ctrl.dividend;
         divisor_in  = ctrl.divisor;
         rem_in      = '0;
      end else if (count_ff != '0) begin
         count_in    = count_ff - 1'b1;
         done_in     = (count_ff == lcg_rrg_pkg::COUNT_WIDTH'(1));
         dividend_in = {dividend_ff[lcg_rrg_pkg::DRAW_WIDTH-2:0], 1'b0};
         if (diff[lcg_rrg_pkg::DATA_WIDTH+1]) begin
            rem_in = trial[lcg_rrg_pkg::DATA_WIDTH-1:0];
         end else begin
            rem_in = diff[lcg_rrg_pkg::DATA_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== src/lcg_random_range_generator_unit.sv =====
// ----------------------------------------------------------------------------
// LCG random range generator
// 64-bit linear congruential generator with optional reduction into a range.
// ----------------------------------------------------------------------------
// Raw draws and empty ranges: ST_MUL_LL, ST_MUL_HL, ST_MUL_LH run three 32x32
// multiplies, then ST_DONE loads the response register once no response is
// stalled and returns to ST_IDLE for the next request. Range draws wait
// in ST_MOD for the one-bit-per-cycle remainder unit (31 steps) before ST_DONE.
// Synchronous active-high reset clears the generator state to zero and empties
// the response register; writing csr_tdata loads the generator state.
module lcg_random_range_generator_unit (
   input  logic        clock,
   input  logic        reset,
   // csr_tdata: seed_init[63:0]
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [63:0] csr_tdata,
   // req_tdata: range_low[31:0], range_high[63:32]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // req_tuser: action[0]
   input  logic [0:0]  req_tuser,
   // rsp_tdata: value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: range_error[0]
   output logic [0:0]  rsp_tuser
);

   localparam int HW = lcg_rrg_pkg::HALF_WIDTH;
   localparam int DW = lcg_rrg_pkg::DATA_WIDTH;

   lcg_rrg_pkg::state_type             state_ff, state_in;
   logic [lcg_rrg_pkg::STATE_WIDTH-1:0] gen_ff, gen_in;
   logic [lcg_rrg_pkg::STATE_WIDTH-1:0] acc_ff, acc_in;
   logic                                action_ff, action_in;
   logic                                bad_ff, bad_in;
   logic signed [DW-1:0]                low_ff, low_in;
   logic [DW-1:0]                       span_ff, span_in;
   logic [DW-1:0]                       res_value_ff, res_value_in;
   logic                                res_error_ff, res_error_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                       rsp_value_ff, rsp_value_in;
   logic                                rsp_error_ff, rsp_error_in;

   logic signed [DW-1:0]                req_low;
   logic signed [DW-1:0]                req_high;
   logic [DW:0]                         req_diff;
   logic [HW-1:0]                       mul_a;
   logic [HW-1:0]                       mul_b;
   logic [2*HW-1:0]                     product;
   logic [HW-1:0]                       mul_sum_hi;
   logic [lcg_rrg_pkg::STATE_WIDTH-1:0] next_gen;
   logic [lcg_rrg_pkg::DRAW_WIDTH-1:0]  draw;
   logic                                req_fire;

   lcg_rrg_pkg::mod_ctrl_type           mod_ctrl;
   lcg_rrg_pkg::mod_status_type         mod_status;

   assign req_low  = req_tdata[DW-1:0];
   assign req_high = req_tdata[2*DW-1:DW];
   assign req_diff = {req_high[DW-1], req_high} - {req_low[DW-1], req_low};

   assign req_tready = (state_ff == lcg_rrg_pkg::ST_IDLE);
   assign csr_tready = (state_ff == lcg_rrg_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Shared 32x32 multiplier: the low 64 bits of state * multiplier are
   // lo*lo + ((hi*lo + lo*hi) << 32), one partial product per cycle.
   always_comb begin
      mul_a = gen_ff[HW-1:0];
      mul_b = lcg_rrg_pkg::LCG_MULTIPLIER[HW-1:0];
      if (state_ff == lcg_rrg_pkg::ST_MUL_HL) begin
         mul_a = gen_ff[2*HW-1:HW];
      end
      if (state_ff == lcg_rrg_pkg::ST_MUL_LH) begin
         mul_b = lcg_rrg_pkg::LCG_MULTIPLIER[2*HW-1:HW];
      end
   end

   assign product    = mul_a * mul_b;
   assign mul_sum_hi = acc_ff[2*HW-1:HW] + product[HW-1:0];
   assign next_gen   = {mul_sum_hi, acc_ff[HW-1:0]};
   assign draw       = next_gen[lcg_rrg_pkg::STATE_WIDTH-1:lcg_rrg_pkg::DRAW_SHIFT];

   assign mod_ctrl.start    = (state_ff == lcg_rrg_pkg::ST_MUL_LH) && action_ff && !bad_ff;
   assign mod_ctrl.dividend = draw;
   assign mod_ctrl.divisor  = span_ff;

   lcg_rrg_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mod_ctrl),
      .status (mod_status)
   );

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      acc_in       = acc_ff;
      action_in    = action_ff;
      bad_in       = bad_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      res_value_in = res_value_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lcg_rrg_pkg::ST_IDLE: begin
            if (csr_tvalid) begin
               gen_in = csr_tdata;
            end
            if (req_fire) begin
               action_in = req_tuser[0];
               bad_in    = (req_high <= req_low);
               low_in    = req_low;
               span_in   = req_diff[DW-1:0];
               state_in  = lcg_rrg_pkg::ST_MUL_LL;
            end
         end
         lcg_rrg_pkg::ST_MUL_LL: begin
            acc_in   = product + lcg_rrg_pkg::LCG_INCREMENT;
            state_in = lcg_rrg_pkg::ST_MUL_HL;
         end
         lcg_rrg_pkg::ST_MUL_HL: begin
            acc_in   = next_gen;
            state_in = lcg_rrg_pkg::ST_MUL_LH;
         end
         lcg_rrg_pkg::ST_MUL_LH: begin
            gen_in = next_gen;
            if (!action_ff) begin
               res_value_in = {{(DW - lcg_rrg_pkg::DRAW_WIDTH){1'b0}}, draw};
               res_error_in = 1'b0;
               state_in     = lcg_rrg_pkg::ST_DONE;
            end else if (bad_ff) begin
               res_value_in = '0;
               res_error_in = 1'b1;
               state_in     = lcg_rrg_pkg::ST_DONE;
            end else begin
               state_in = lcg_rrg_pkg::ST_MOD;
            end
         end
         lcg_rrg_pkg::ST_MOD: begin
            if (mod_status.done) begin
               // The result lies inside the range, so a wrapping add is exact.
               res_value_in = low_ff + mod_status.remainder;
               res_error_in = 1'b0;
               state_in     = lcg_rrg_pkg::ST_DONE;
            end
         end
         lcg_rrg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_error_in = res_error_ff;
               state_in     = lcg_rrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcg_rrg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcg_rrg_pkg::ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      action_ff    <= action_in;
      bad_ff       <= bad_in;
      low_ff       <= low_in;
      span_ff      <= span_in;
      res_value_ff <= res_value_in;
      res_error_ff <= res_error_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_error_ff;

endmodule

// ===== src/lcg_rrg_checker.sv =====
// ----------------------------------------------------------------------------
// LCG random range generator port checker
// Concurrent checks on the top level's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "lcg_random_range_generator_unit_assert.svh"

module lcg_rrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_tready,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic        req_fire;
   logic        rsp_stall;
   logic [32:0] rsp_word;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // A stalled response keeps its value and flag.
   `LCG_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "stalled response changed")

   // An empty range always reports a zero value.
   `LCG_ASSERT_SAME(a_error_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == 32'd0, "range error with nonzero value")

   // The generator works on one request at a time.
   `LCG_ASSERT_NEXT(a_busy_after_req, req_fire, !req_tready && !csr_tready, "ready right after a request")

   // The seed may only be loaded when no request is in flight.
   `LCG_ASSERT_SAME(a_csr_idle, csr_tready, req_tready, "seed port ready while busy")

endmodule

bind lcg_random_range_generator_unit lcg_rrg_checker u_lcg_rrg_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_tready (csr_tready),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
